/* sv/cvit_pkg.sv */
// ============================================================================
// cvit_pkg
// Shared types and constants for the conserved-region Viterbi segmenter.
// ============================================================================
package cvit_pkg;

    localparam int MAX_COLUMNS_DEF = 4096;

    // Widths of the fixed result fields
    localparam int OUT_W   = 13;
    localparam int TOTAL_W = 31;
    localparam int SCORE_W = 32;
    localparam int REG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] GAP_CHAR = 8'h2D;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXTEND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_MODE = 3'd4;

    // Reset values of the configuration registers
    localparam logic signed [REG_W-1:0] GAP_OPEN_RST   = -16'sd1500;
    localparam logic signed [REG_W-1:0] GAP_EXTEND_RST = -16'sd50;
    localparam logic signed [REG_W-1:0] MATCH_RST      = 16'sd102;
    localparam logic signed [REG_W-1:0] MISMATCH_RST   = -16'sd91;

    // Bound combining modes
    localparam logic [1:0] BM_NONE      = 2'd0;
    localparam logic [1:0] BM_INTERSECT = 2'd1;
    localparam logic [1:0] BM_UNION     = 2'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Result of one forward recursion step
    typedef struct packed {
        logic                      skip;     // both rows are gaps
        logic signed [SCORE_W-1:0] score_c;
        logic signed [SCORE_W-1:0] score_n;
        logic [1:0]                bp;       // bit0: C predecessor, bit1: N predecessor
    } t_fwd_res;

endpackage

/* sv/conserved_region_viterbi.sv */
// Conserved-region segmenter. Send one alignment column per request; a column
// without last_column is taken without a stall. The column that carries
// last_column starts a traceback that walks the stored backpointers from the
// last scored column back to the first, one entry per cycle through the single
// read port of the backpointer memory; o_stall holds off later columns until
// the result is in the output register. One result comes out per pair. No
// memory clearing is needed after reset. The user must make configuration
// writes only while the input side is idle; the block does not enforce this.
// ============================================================================
// conserved_region_viterbi
// Two-state Viterbi segmentation of pairwise alignment columns with traceback,
// region bounds and a saturating running total.
// ============================================================================
module conserved_region_viterbi #(
    parameter int MAX_COLUMNS = cvit_pkg::MAX_COLUMNS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cvit_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cvit_pkg::REG_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_base_a,
    input  logic [7:0]                        i_base_b,
    input  logic                              i_last_column,
    input  logic                              i_first_pair,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [cvit_pkg::OUT_W-1:0]        o_conserved_count,
    output logic [cvit_pkg::TOTAL_W-1:0]      o_total_conserved,
    output logic [cvit_pkg::OUT_W-1:0]        o_region_left,
    output logic [cvit_pkg::OUT_W-1:0]        o_region_right,
    output logic [cvit_pkg::OUT_W-1:0]        o_bound_left_out,
    output logic [cvit_pkg::OUT_W-1:0]        o_bound_right_out,
    output logic                              o_found
);
    import cvit_pkg::*;

    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int CW = $clog2(MAX_COLUMNS + 2);
    localparam int MW = CW + 2;
    localparam int XW = (CW > OUT_W) ? CW : OUT_W;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_COLUMNS);
    localparam logic [CW-1:0] MAX_C1 = CW'(MAX_COLUMNS + 1);
    localparam logic [CW-1:0] ONE_C  = CW'(1);
    localparam logic [CW-1:0] TWO_C  = CW'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_TRACE,
        ST_FINISH
    } t_state;

    // Configuration
    logic signed [REG_W-1:0] r_gap_open, r_gap_extend, r_match, r_mismatch;
    logic [1:0]              r_bound_mode;

    // Recursion and pair state
    t_state                    r_state;
    logic signed [SCORE_W-1:0] r_score_c, r_score_n;
    logic [CW-1:0]             r_pair_len, r_align_len;
    logic [CW-1:0]             r_bound_l, r_bound_r;
    logic [TOTAL_W-1:0]        r_total;

    // Traceback
    logic [CW-1:0] r_idx, r_cnt, r_lo_map, r_hi_map;
    logic          r_s, r_hi_found;

    // Output register
    logic               r_ovalid;
    logic [OUT_W-1:0]   r_o_cnt, r_o_left, r_o_right, r_o_bl, r_o_br;
    logic [TOTAL_W-1:0] r_o_total;
    logic               r_o_found;

    t_fwd_res      w_fwd;
    logic          w_accept, w_room, w_we;
    logic [MW-1:0] w_wdata, w_rdata;
    logic [CW-1:0] w_ra_full, w_map;
    logic [1:0]    w_bp;

    logic [CW-1:0]      n_bound_l, n_bound_r, n_left, n_right;
    logic [TOTAL_W:0]   w_sum;
    logic [TOTAL_W-1:0] n_total;
    logic               w_out_free;
    logic [XW-1:0]      w_x_cnt, w_x_left, w_x_right, w_x_bl, w_x_br;

    cvit_fwd u_fwd (
        .i_base_a     (i_base_a),
        .i_base_b     (i_base_b),
        .i_score_c    (r_score_c),
        .i_score_n    (r_score_n),
        .i_gap_open   (r_gap_open),
        .i_gap_extend (r_gap_extend),
        .i_match      (r_match),
        .i_mismatch   (r_mismatch),
        .o_res        (w_fwd)
    );

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_room   = (r_align_len < MAX_C);
    assign w_we     = w_accept && w_room && !w_fwd.skip;
    assign w_wdata  = {w_fwd.bp, CW'(r_align_len + ONE_C)};

    // Reads stream from the last scored entry down to entry zero
    assign w_ra_full = (r_state == ST_START) ? CW'(r_pair_len - ONE_C)
                                             : CW'(r_idx - TWO_C);

    cvit_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_COLUMNS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pair_len[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_ra_full[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_bp  = w_rdata[MW-1:CW];
    assign w_map = w_rdata[CW-1:0];

    // Pair summary and bound update
    always_comb begin
        n_bound_l = r_bound_l;
        n_bound_r = r_bound_r;
        n_left    = '0;
        n_right   = '0;
        if (r_cnt != '0) begin
            n_left  = r_lo_map;
            n_right = r_hi_map;
            if (r_bound_mode == BM_INTERSECT) begin
                if (r_lo_map > r_bound_l) n_bound_l = r_lo_map;
                if (r_hi_map < r_bound_r) n_bound_r = r_hi_map;
            end else if (r_bound_mode == BM_UNION) begin
                if (r_lo_map < r_bound_l) n_bound_l = r_lo_map;
                if (r_hi_map > r_bound_r) n_bound_r = r_hi_map;
            end
        end else begin
            n_bound_l = ONE_C;
            n_bound_r = r_align_len;
        end
    end

    assign w_sum   = {1'b0, r_total} + (TOTAL_W + 1)'(r_cnt);
    assign n_total = w_sum[TOTAL_W] ? TOTAL_MAX : w_sum[TOTAL_W-1:0];

    assign w_x_cnt   = XW'(r_cnt);
    assign w_x_left  = XW'(n_left);
    assign w_x_right = XW'(n_right);
    assign w_x_bl    = XW'(n_bound_l);
    assign w_x_br    = XW'(n_bound_r);

    assign w_out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_open   <= GAP_OPEN_RST;
            r_gap_extend <= GAP_EXTEND_RST;
            r_match      <= MATCH_RST;
            r_mismatch   <= MISMATCH_RST;
            r_bound_mode <= BM_NONE;
            r_state      <= ST_IDLE;
            r_score_c    <= '0;
            r_score_n    <= '0;
            r_pair_len   <= '0;
            r_align_len  <= '0;
            r_bound_l    <= '0;
            r_bound_r    <= '0;
            r_total      <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAP_OPEN:   r_gap_open   <= i_cfg_data;
                    CFG_GAP_EXTEND: r_gap_extend <= i_cfg_data;
                    CFG_MATCH:      r_match      <= i_cfg_data;
                    CFG_MISMATCH:   r_mismatch   <= i_cfg_data;
                    CFG_BOUND_MODE: r_bound_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            if (r_state == ST_FINISH && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_first_pair) begin
                            r_total <= '0;
                            case (r_bound_mode)
                                BM_INTERSECT: begin
                                    r_bound_l <= '0;
                                    r_bound_r <= MAX_C;
                                end
                                BM_UNION: begin
                                    r_bound_l <= MAX_C1;
                                    r_bound_r <= '0;
                                end
                                default: begin
                                    r_bound_l <= '0;
                                    r_bound_r <= '0;
                                end
                            endcase
                        end
                        if (w_room) begin
                            r_align_len <= r_align_len + ONE_C;
                            if (!w_fwd.skip) begin
                                r_score_c  <= w_fwd.score_c;
                                r_score_n  <= w_fwd.score_n;
                                r_pair_len <= r_pair_len + ONE_C;
                            end
                        end
                        if (i_last_column) begin
                            r_state <= ST_START;
                        end
                    end
                end
                ST_START: begin
                    r_s        <= !(r_score_c > r_score_n);
                    r_cnt      <= '0;
                    r_hi_found <= 1'b0;
                    r_lo_map   <= '0;
                    r_hi_map   <= '0;
                    r_idx      <= r_pair_len;
                    r_state    <= (r_pair_len == '0) ? ST_FINISH : ST_TRACE;
                end
                ST_TRACE: begin
                    if (!r_s) begin
                        r_cnt    <= r_cnt + ONE_C;
                        r_lo_map <= w_map;
                        if (!r_hi_found) begin
                            r_hi_map   <= w_map;
                            r_hi_found <= 1'b1;
                        end
                    end
                    r_s   <= r_s ? w_bp[1] : w_bp[0];
                    r_idx <= r_idx - ONE_C;
                    if (r_idx == ONE_C) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // hold until the output register can take the result
                    if (w_out_free) begin
                        r_o_cnt     <= w_x_cnt[OUT_W-1:0];
                        r_o_left    <= w_x_left[OUT_W-1:0];
                        r_o_right   <= w_x_right[OUT_W-1:0];
                        r_o_bl      <= w_x_bl[OUT_W-1:0];
                        r_o_br      <= w_x_br[OUT_W-1:0];
                        r_o_total   <= n_total;
                        r_o_found   <= (r_cnt != '0);
                        r_bound_l   <= n_bound_l;
                        r_bound_r   <= n_bound_r;
                        r_total     <= n_total;
                        r_score_c   <= '0;
                        r_score_n   <= '0;
                        r_pair_len  <= '0;
                        r_align_len <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_conserved_count = r_o_cnt;
    assign o_total_conserved = r_o_total;
    assign o_region_left     = r_o_left;
    assign o_region_right    = r_o_right;
    assign o_bound_left_out  = r_o_bl;
    assign o_bound_right_out = r_o_br;
    assign o_found           = r_o_found;

    a_last_starts_trace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_column) |=> (r_state == ST_START))
        else $error("last column did not start traceback");

    a_pair_within_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pair_len <= r_align_len) && (r_align_len <= MAX_C))
        else $error("pair length exceeds alignment length");

    a_trace_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TRACE) |-> ((r_idx != '0) && (r_idx <= r_pair_len)))
        else $error("traceback index out of range");

    a_finish_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && w_out_free) |=> (o_valid && r_state == ST_IDLE))
        else $error("finished pair did not reach the output register");

endmodule

/* sv/cvit_ram.sv */
// ============================================================================
// cvit_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module cvit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/cvit_fwd.sv */
// ============================================================================
// cvit_fwd
// One column of the two-state Viterbi recursion with saturating scores.
// ============================================================================
module cvit_fwd (
    input  logic [7:0]                                   i_base_a,
    input  logic [7:0]                                   i_base_b,
    input  logic signed [cvit_pkg::SCORE_W-1:0]          i_score_c,
    input  logic signed [cvit_pkg::SCORE_W-1:0]          i_score_n,
    input  logic signed [cvit_pkg::REG_W-1:0]            i_gap_open,
    input  logic signed [cvit_pkg::REG_W-1:0]            i_gap_extend,
    input  logic signed [cvit_pkg::REG_W-1:0]            i_match,
    input  logic signed [cvit_pkg::REG_W-1:0]            i_mismatch,
    output cvit_pkg::t_fwd_res                           o_res
);
    import cvit_pkg::*;

    localparam int WW = SCORE_W + 2;
    localparam logic signed [WW-1:0] SAT_MAX = 34'sd2147483647;
    localparam logic signed [WW-1:0] SAT_MIN = -34'sd2147483648;

    function automatic logic is_base(input logic [7:0] c);
        return (c == 8'h41) || (c == 8'h43) || (c == 8'h47) || (c == 8'h54);
    endfunction

    function automatic logic signed [WW-1:0] clamp(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] r;
        r = v;
        if (v > SAT_MAX) r = SAT_MAX;
        if (v < SAT_MIN) r = SAT_MIN;
        return r;
    endfunction

    logic signed [REG_W-1:0] w_col;
    logic signed [WW-1:0]    w_cn, w_nc, w_go;
    logic signed [WW-1:0]    w_c_via_n, w_n_via_c;
    logic signed [WW-1:0]    w_c_best, w_n_best;
    logic signed [WW-1:0]    w_c_new, w_n_sat, w_c_sat;
    logic                    w_bp_c, w_bp_n;

    always_comb begin
        if (i_base_a == GAP_CHAR || i_base_b == GAP_CHAR) begin
            w_col = i_gap_extend;
        end else if (is_base(i_base_a) && is_base(i_base_b)) begin
            w_col = (i_base_a == i_base_b) ? i_match : i_mismatch;
        end else begin
            w_col = '0;
        end
    end

    assign w_cn = WW'(i_score_c);
    assign w_nc = WW'(i_score_n);
    assign w_go = WW'(i_gap_open);

    assign w_c_via_n = w_nc + w_go;
    assign w_n_via_c = w_cn + w_go;

    // Staying in C needs a strictly greater score; a tie takes the path from N
    assign w_bp_c   = !(w_cn > w_c_via_n);
    assign w_c_best = w_bp_c ? w_c_via_n : w_cn;
    assign w_c_new  = w_c_best + WW'(w_col);

    assign w_bp_n   = !(w_n_via_c > w_nc);
    assign w_n_best = w_bp_n ? w_nc : w_n_via_c;

    assign w_c_sat = clamp(w_c_new);
    assign w_n_sat = clamp(w_n_best);

    assign o_res.skip    = (i_base_a == GAP_CHAR) && (i_base_b == GAP_CHAR);
    assign o_res.score_c = w_c_sat[SCORE_W-1:0];
    assign o_res.score_n = w_n_sat[SCORE_W-1:0];
    assign o_res.bp      = {w_bp_n, w_bp_c};

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the conserved-region Viterbi segmenter: alignment
// columns go in as requests and a bit-accurate scoreboard model predicts the
// traceback result of each pair. Directed pairs cover scoring, ties, the
// trailing one-column run and the bound modes. Random phases then vary the
// settings, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cvit_pkg::*;

    localparam int COLS        = MAX_COLUMNS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [31:0] BASE_SET = "ACGT";

    typedef struct {
        int     count;
        longint total;
        int     left;
        int     right;
        int     bnd_left;
        int     bnd_right;
        bit     found;
    } t_region;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [REG_W-1:0]      i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_base_a;
    logic [7:0]            i_base_b;
    logic                  i_last_column;
    logic                  i_first_pair;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [OUT_W-1:0]      o_conserved_count;
    logic [TOTAL_W-1:0]    o_total_conserved;
    logic [OUT_W-1:0]      o_region_left;
    logic [OUT_W-1:0]      o_region_right;
    logic [OUT_W-1:0]      o_bound_left_out;
    logic [OUT_W-1:0]      o_bound_right_out;
    logic                  o_found;

    // Scoreboard model state
    logic signed [REG_W-1:0] cfg_gap_open   = GAP_OPEN_RST;
    logic signed [REG_W-1:0] cfg_gap_extend = GAP_EXTEND_RST;
    logic signed [REG_W-1:0] cfg_match      = MATCH_RST;
    logic signed [REG_W-1:0] cfg_mismatch   = MISMATCH_RST;
    logic [1:0]              cfg_bound_mode = BM_NONE;

    logic signed [SCORE_W-1:0] score_c = '0;
    logic signed [SCORE_W-1:0] score_n = '0;
    logic [1:0]                trace_ptrs [COLS];
    int                        col_pos    [COLS];
    int                        scored_cols = 0;
    int                        aln_cols    = 0;
    int                        bnd_left    = 0;
    int                        bnd_right   = 0;
    longint                    running_sum = 0;

    t_region expected_regions [$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatches         = 0;
    int columns_sent       = 0;
    int pairs_checked      = 0;
    int settings_written   = 0;
    int cycles             = 0;

    conserved_region_viterbi dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_base_a          (i_base_a),
        .i_base_b          (i_base_b),
        .i_last_column     (i_last_column),
        .i_first_pair      (i_first_pair),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_conserved_count (o_conserved_count),
        .o_total_conserved (o_total_conserved),
        .o_region_left     (o_region_left),
        .o_region_right    (o_region_right),
        .o_bound_left_out  (o_bound_left_out),
        .o_bound_right_out (o_bound_right_out),
        .o_found           (o_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic longint column_score(logic [7:0] a, logic [7:0] b);
        if (a == GAP_CHAR || b == GAP_CHAR)
            return longint'(cfg_gap_extend);
        if ((a inside {"A", "C", "G", "T"}) && (b inside {"A", "C", "G", "T"}))
            return (a == b) ? longint'(cfg_match) : longint'(cfg_mismatch);
        return 0;
    endfunction

    function automatic logic signed [SCORE_W-1:0] sat_score(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[SCORE_W-1:0];
    endfunction

    // Advance the model by one accepted column; queue a result on last_column.
    task automatic segment_column(logic [7:0] a, logic [7:0] b, bit last, bit first);
        longint     go, c_prev, n_prev, new_c, new_n;
        logic [1:0] bp;
        int         state, lo, hi;
        t_region    r;
        if (first) begin
            running_sum = 0;
            case (cfg_bound_mode)
                BM_INTERSECT: begin bnd_left = 0;        bnd_right = COLS; end
                BM_UNION:     begin bnd_left = COLS + 1; bnd_right = 0;    end
                default:      begin bnd_left = 0;        bnd_right = 0;    end
            endcase
        end
        if (aln_cols < COLS) begin
            aln_cols++;
            if (!(a == GAP_CHAR && b == GAP_CHAR)) begin
                go = longint'(cfg_gap_open);
                c_prev = score_c;
                n_prev = score_n;
                if (c_prev > n_prev + go) begin
                    new_c = c_prev;
                    bp = 2'b00;
                end else begin
                    new_c = n_prev + go;
                    bp = 2'b01;
                end
                new_c += column_score(a, b);
                if (c_prev + go > n_prev) begin
                    new_n = c_prev + go;
                end else begin
                    new_n = n_prev;
                    bp[1] = 1'b1;
                end
                score_c = sat_score(new_c);
                score_n = sat_score(new_n);
                trace_ptrs[scored_cols] = bp;
                col_pos[scored_cols] = aln_cols;
                scored_cols++;
            end
        end
        if (!last)
            return;

        r = '{default: 0};
        lo = 0;
        hi = 0;
        state = (score_c > score_n) ? 0 : 1;
        for (int i = scored_cols; i > 0; i--) begin
            if (state == 0) begin
                r.count++;
                if (hi == 0)
                    hi = i;
                lo = i;
            end
            state = (trace_ptrs[i-1] >> state) & 1;
        end

        if (r.count > 0) begin
            r.left = col_pos[lo-1];
            r.right = col_pos[hi-1];
            if (cfg_bound_mode == BM_INTERSECT) begin
                if (r.left > bnd_left) bnd_left = r.left;
                if (r.right < bnd_right) bnd_right = r.right;
            end else if (cfg_bound_mode == BM_UNION) begin
                if (r.left < bnd_left) bnd_left = r.left;
                if (r.right > bnd_right) bnd_right = r.right;
            end
        end else begin
            bnd_left = 1;
            bnd_right = aln_cols;
        end

        if (r.count > longint'(TOTAL_MAX) - running_sum)
            running_sum = longint'(TOTAL_MAX);
        else
            running_sum += r.count;

        r.total = running_sum;
        r.bnd_left = bnd_left & 32'h1FFF;
        r.bnd_right = bnd_right & 32'h1FFF;
        r.found = (r.count > 0);
        expected_regions.push_back(r);

        score_c = '0;
        score_n = '0;
        scored_cols = 0;
        aln_cols = 0;
    endtask

    task automatic check_field(string name, longint want_v, logic [31:0] got);
        if (got !== want_v[31:0]) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got);
            mismatches++;
        end
    endtask

    // Compare each accepted result against the oldest prediction, then stall at random.
    always @(posedge i_clk) begin : check_results
        t_region want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_regions.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got count %0d",
                             $time, o_conserved_count);
                    mismatches++;
                end else begin
                    want = expected_regions.pop_front();
                    check_field("conserved_count", want.count, 32'(o_conserved_count));
                    check_field("total_conserved", want.total, 32'(o_total_conserved));
                    check_field("region_left", want.left, 32'(o_region_left));
                    check_field("region_right", want.right, 32'(o_region_right));
                    check_field("bound_left_out", want.bnd_left, 32'(o_bound_left_out));
                    check_field("bound_right_out", want.bnd_right, 32'(o_bound_right_out));
                    check_field("found", want.found, 32'(o_found));
                    pairs_checked++;
                end
            end
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Send one column request; valid stays high after acceptance for back-to-back requests.
    task automatic send_column(logic [7:0] a, logic [7:0] b, bit last, bit first);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_valid <= 1'b1;
        i_base_a <= a;
        i_base_b <= b;
        i_last_column <= last;
        i_first_pair <= first;
        do @(posedge i_clk); while (o_stall);
        segment_column(a, b, last, first);
        columns_sent++;
    endtask

    task automatic send_pattern(string a_row, string b_row, bit first);
        for (int k = 0; k < a_row.len(); k++)
            send_column(a_row[k], b_row[k], k == a_row.len() - 1, first && k == 0);
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_regions.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_GAP_OPEN:   cfg_gap_open = data;
            CFG_GAP_EXTEND: cfg_gap_extend = data;
            CFG_MATCH:      cfg_match = data;
            CFG_MISMATCH:   cfg_mismatch = data;
            CFG_BOUND_MODE: cfg_bound_mode = data[1:0];
            default: ;
        endcase
        settings_written++;
    endtask

    task automatic apply_settings(logic [15:0] go, logic [15:0] ge, logic [15:0] ms,
                                  logic [15:0] mm, logic [1:0] mode);
        settle();
        write_reg(CFG_GAP_OPEN, go);
        write_reg(CFG_GAP_EXTEND, ge);
        write_reg(CFG_MATCH, ms);
        write_reg(CFG_MISMATCH, mm);
        write_reg(CFG_BOUND_MODE, {14'($urandom), mode});
        // unmapped index, must be ignored
        write_reg(CFG_IDX_W'(CFG_BOUND_MODE + 1 + $urandom_range(2)), 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_pair(int len, bit new_group);
        logic [7:0] a, b;
        bit         similar;
        int         roll;
        similar = $urandom_range(1);
        for (int j = 0; j < len; j++) begin
            if ($urandom_range(99) < 12)
                similar = !similar;
            a = BASE_SET[8 * $urandom_range(3) +: 8];
            b = (similar && $urandom_range(99) < 90) ? a : BASE_SET[8 * $urandom_range(3) +: 8];
            roll = $urandom_range(99);
            if (roll < 4) begin
                a = GAP_CHAR;
                b = GAP_CHAR;
            end else if (roll < 10) a = GAP_CHAR;
            else if (roll < 16) b = GAP_CHAR;
            else if (roll < 19) a = 8'($urandom_range(255));
            else if (roll < 22) b = 8'($urandom_range(255));
            send_column(a, b, j == len - 1, (j == 0 && new_group) || $urandom_range(99) == 0);
        end
    endtask

    function automatic logic [15:0] pick_penalty();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h0000;
            default: return 16'(-int'($urandom_range(2500)));
        endcase
    endfunction

    // Reset settings; gaps, non-bases and mismatches; no first_pair so reset bounds show.
    task automatic test_default_scoring();
        send_pattern("AC-T-NG", "AC--ANT", 1'b0);
    endtask

    task automatic test_single_columns();
        send_pattern("-", "-", 1'b1);
        send_pattern("A", "A", 1'b0);
    endtask

    task automatic test_score_ties();
        apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, BM_NONE);
        send_pattern("ACG", "ACT", 1'b0);
    endtask

    // Extreme register values, odd bytes and bound mode three.
    task automatic test_extreme_settings();
        apply_settings(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 2'd3);
        send_column(8'h00, 8'hFF, 1'b0, 1'b1);
        send_column("T", "T", 1'b1, 1'b0);
    endtask

    // Conserved run of one column at the very end of the pair.
    task automatic test_trailing_run();
        apply_settings(16'(-100), 16'h8000, 16'h7FFF, 16'h8000, BM_NONE);
        send_pattern("GAT", "C-T", 1'b0);
    endtask

    task automatic test_bound_combining();
        apply_settings(16'(-300), 16'(-50), 16'd102, 16'(-91), BM_INTERSECT);
        send_pattern("TAC", "GAC", 1'b1);
        send_pattern("ACG", "ACT", 1'b0);
        apply_settings(16'(-300), 16'(-50), 16'd102, 16'(-91), BM_UNION);
        send_pattern("GAC", "TAC", 1'b1);
        send_pattern("GG", "CC", 1'b0);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, int n_cols);
        int         sent, len;
        logic [15:0] ms, mm;
        for (int half = 0; half < 2; half++) begin
            case ($urandom_range(9))
                0: ms = 16'h7FFF;
                1: ms = 16'h8000;
                default: ms = 16'($urandom_range(300));
            endcase
            case ($urandom_range(9))
                0: mm = 16'h8000;
                1: mm = 16'h7FFF;
                default: mm = 16'(-int'($urandom_range(300)));
            endcase
            apply_settings(pick_penalty(), pick_penalty(), ms, mm, 2'($urandom_range(3)));
            sender_idle_pct = idle_pct;
            receiver_stall_pct = stall_pct;
            sent = 0;
            while (sent < n_cols / 2) begin
                case ($urandom_range(99)) inside
                    [0:79]:  len = $urandom_range(30, 1);
                    [80:96]: len = $urandom_range(120, 31);
                    default: len = $urandom_range(400, 121);
                endcase
                // trim the last pair so the phase sends its exact share
                if (len > n_cols / 2 - sent)
                    len = n_cols / 2 - sent;
                send_random_pair(len, $urandom_range(99) < 35);
                sent += len;
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_GAP_OPEN;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_base_a <= '0;
        i_base_b <= '0;
        i_last_column <= 1'b0;
        i_first_pair <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_scoring();
        test_single_columns();
        test_score_ties();
        test_extreme_settings();
        test_trailing_run();
        test_bound_combining();
        test_random_traffic(0, 0, 256);
        test_random_traffic(51, 0, 256);
        test_random_traffic(0, 51, 256);
        test_random_traffic(38, 38, 256);

        settle();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (16) @(posedge i_clk);

        $display("covered %0d columns and %0d pair results over %0d register writes",
                 columns_sent, pairs_checked, settings_written);
        $display("includes ties, extremes, all bound modes, gaps and stalls");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
sv/cvit_pkg.sv
sv/cvit_ram.sv
sv/cvit_fwd.sv
sv/conserved_region_viterbi.sv
test/tb_top.sv
